FILE: rtl/fgal_pkg.sv
// Package: shared constants, codes, types and state encoding for the glyph address unit
package fgal_pkg;

    localparam int MAX_BLOCKS_DEF      = 256;
    localparam int GLYPH_BUF_BYTES_DEF = 128;
    localparam int NUM_SLOTS_DEF       = 2;

    localparam logic [1:0]  KIND_SINGLE   = 2'd1;
    localparam logic [1:0]  KIND_DOUBLE   = 2'd2;
    localparam logic [15:0] CODE_SB_LIMIT = 16'h0100;
    localparam logic [10:0] SB_BASE       = 11'd17;
    localparam logic [10:0] DB_BASE       = 11'd18;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic [7:0] REG_S0_KIND   = 8'd0;
    localparam logic [7:0] REG_S0_WIDTH  = 8'd1;
    localparam logic [7:0] REG_S0_HEIGHT = 8'd2;
    localparam logic [7:0] REG_S0_BLOCKS = 8'd3;
    localparam logic [7:0] REG_S1_KIND   = 8'd4;
    localparam logic [7:0] REG_S1_WIDTH  = 8'd5;
    localparam logic [7:0] REG_S1_HEIGHT = 8'd6;
    localparam logic [7:0] REG_S1_BLOCKS = 8'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ADD
    } t_state;

    // lookup token passed along the cell row
    typedef struct packed {
        logic             valid;
        logic [15:0]      code;
        logic [1:0]       hit;
        logic [1:0][15:0] idx;
    } t_token;

    typedef struct packed {
        logic [1:0][7:0] blocks;
    } t_walk_cfg;

    typedef struct packed {
        logic        we;
        logic        slot;
        logic [7:0]  index;
        logic [15:0] first;
        logic [15:0] last;
    } t_load;

endpackage

FILE: rtl/fgal_if.sv
// Interfaces: request, result and register write channels
interface fgal_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic        table_slot;
    logic [7:0]  block_index;
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic [15:0] char_code;
    modport source (output valid, operation, table_slot, block_index, range_start,
                    range_end, char_code, input ready);
    modport sink   (input valid, operation, table_slot, block_index, range_start,
                    range_end, char_code, output ready);
endinterface

interface fgal_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        font_slot;
    logic [23:0] byte_offset;
    logic [7:0]  glyph_bytes;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    modport source (output valid, found, font_slot, byte_offset, glyph_bytes,
                    glyph_width, glyph_height, input ready);
    modport sink   (input valid, found, font_slot, byte_offset, glyph_bytes,
                    glyph_width, glyph_height, output ready);
endinterface

interface fgal_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/fgal_cell.sv
// Block cell: holds one block entry per slot and advances the lookup token
module fgal_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fgal_pkg::t_load    i_load,
    input  fgal_pkg::t_walk_cfg i_cfg,
    input  fgal_pkg::t_token   i_tok,
    output fgal_pkg::t_token   o_tok
);
    logic [1:0][15:0] r_first;
    logic [1:0][15:0] r_last;
    fgal_pkg::t_token r_tok;
    fgal_pkg::t_token n_tok;

    always_comb begin
        n_tok = i_tok;
        for (int s = 0; s < 2; s++) begin
            if (i_tok.valid && !i_tok.hit[s] && ({1'b0, i_cfg.blocks[s]} > 9'(CELL_IDX))) begin
                if (i_tok.code >= r_first[s] && i_tok.code <= r_last[s]) begin
                    n_tok.hit[s] = 1'b1;
                    n_tok.idx[s] = i_tok.idx[s] + (i_tok.code - r_first[s]);
                end else begin
                    n_tok.idx[s] = i_tok.idx[s] + (r_last[s] - r_first[s] + 16'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we && i_load.index == 8'(CELL_IDX)) begin
            r_first[i_load.slot] <= i_load.first;
            r_last[i_load.slot]  <= i_load.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end
    end

    assign o_tok = r_tok;
endmodule

FILE: rtl/font_glyph_address_lookup.sv
// Top level: glyph address unit with a row of block cells
// A load writes one block entry of the row in place. In a lookup the token
// passes the row of MAX_BLOCKS cells, one cell a cycle, checking both slots
// side by side; then the glyph index times the glyph size is registered, and
// the header base is added as the result enters the output register. One
// item is in work at a time; a result waits in the output register until
// taken.
module font_glyph_address_lookup #(
    parameter int MAX_BLOCKS      = fgal_pkg::MAX_BLOCKS_DEF,
    parameter int GLYPH_BUF_BYTES = fgal_pkg::GLYPH_BUF_BYTES_DEF,
    parameter int NUM_SLOTS       = fgal_pkg::NUM_SLOTS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    fgal_in_if.sink    i_in,
    fgal_out_if.source o_out,
    fgal_cfg_if.sink   i_cfg
);
    fgal_pkg::t_state r_state;
    fgal_pkg::t_state n_state;

    logic [1:0][1:0]  r_kind;
    logic [1:0][7:0]  r_width;
    logic [1:0][7:0]  r_height;
    logic [1:0][7:0]  r_blocks;
    logic [1:0][12:0] r_size;

    fgal_pkg::t_token  w_tok [MAX_BLOCKS+1];
    fgal_pkg::t_load   w_load;
    fgal_pkg::t_walk_cfg w_wcfg;

    logic        r_found;
    logic        r_slot;
    logic        r_sb;
    logic [28:0] r_prod;

    logic        r_oval;
    logic        r_ofound;
    logic        r_oslot;
    logic [23:0] r_offset;
    logic [7:0]  r_obytes;
    logic [7:0]  r_owidth;
    logic [7:0]  r_oheight;

    logic        w_acc;
    logic        w_sb;
    logic [1:0]  w_hitslot;
    logic        w_sel;
    logic [15:0] w_mul_a;
    logic [10:0] w_base;

    assign i_in.ready  = (r_state == fgal_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_acc       = i_in.valid && i_in.ready;

    assign w_load.we    = w_acc && i_in.operation == fgal_pkg::OP_LOAD
                          && (NUM_SLOTS > int'(i_in.table_slot));
    assign w_load.slot  = i_in.table_slot;
    assign w_load.index = i_in.block_index;
    assign w_load.first = i_in.range_start;
    assign w_load.last  = i_in.range_end;
    assign w_wcfg.blocks = r_blocks;

    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_acc && i_in.operation == fgal_pkg::OP_LOOKUP;
        w_tok[0].code  = i_in.char_code;
    end

    for (genvar b = 0; b < MAX_BLOCKS; b++) begin : g_cell
        fgal_cell #(.CELL_IDX(b)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_load (w_load),
            .i_cfg  (w_wcfg),
            .i_tok  (w_tok[b]),
            .o_tok  (w_tok[b+1])
        );
    end

    // slot selection at the end of the row
    always_comb begin
        w_sb = w_tok[MAX_BLOCKS].code < fgal_pkg::CODE_SB_LIMIT;
        for (int s = 0; s < 2; s++) begin
            w_hitslot[s] = (NUM_SLOTS > s)
                && r_size[s] <= 13'(GLYPH_BUF_BYTES)
                && (w_sb ? r_kind[s] == fgal_pkg::KIND_SINGLE
                         : (r_kind[s] == fgal_pkg::KIND_DOUBLE && w_tok[MAX_BLOCKS].hit[s]));
        end
        w_sel   = !w_hitslot[0];
        w_mul_a = w_sb ? {8'd0, w_tok[MAX_BLOCKS].code[7:0]} : w_tok[MAX_BLOCKS].idx[w_sel];
        w_base  = r_sb ? fgal_pkg::SB_BASE
                       : fgal_pkg::DB_BASE + {1'b0, r_blocks[r_slot], 2'b00};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fgal_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_state = (i_in.operation == fgal_pkg::OP_LOAD) ? fgal_pkg::ST_ADD
                                                                     : fgal_pkg::ST_WALK;
                end
            end
            fgal_pkg::ST_WALK: begin
                if (w_tok[MAX_BLOCKS].valid) begin
                    n_state = fgal_pkg::ST_ADD;
                end
            end
            fgal_pkg::ST_ADD: begin
                if (!r_oval || o_out.ready) begin
                    n_state = fgal_pkg::ST_IDLE;
                end
            end
            default: n_state = fgal_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fgal_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= {2'd0, 2'd0};
            r_width  <= {8'd16, 8'd8};
            r_height <= {8'd16, 8'd16};
            r_blocks <= {8'd0, 8'd0};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                fgal_pkg::REG_S0_KIND:   r_kind[0]   <= i_cfg.data[1:0];
                fgal_pkg::REG_S0_WIDTH:  r_width[0]  <= i_cfg.data;
                fgal_pkg::REG_S0_HEIGHT: r_height[0] <= i_cfg.data;
                fgal_pkg::REG_S0_BLOCKS: r_blocks[0] <= i_cfg.data;
                fgal_pkg::REG_S1_KIND:   r_kind[1]   <= i_cfg.data[1:0];
                fgal_pkg::REG_S1_WIDTH:  r_width[1]  <= i_cfg.data;
                fgal_pkg::REG_S1_HEIGHT: r_height[1] <= i_cfg.data;
                fgal_pkg::REG_S1_BLOCKS: r_blocks[1] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int s = 0; s < 2; s++) begin
                r_size[s] <= 13'(({1'b0, r_width[s][7:3]} + {5'd0, |r_width[s][2:0]})
                                 * r_height[s]);
            end
            r_found <= 1'b0;
        end
        if (r_state == fgal_pkg::ST_WALK && w_tok[MAX_BLOCKS].valid) begin
            r_found <= |w_hitslot;
            r_slot  <= w_sel;
            r_sb    <= w_sb;
            r_prod  <= w_mul_a * r_size[w_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (r_state == fgal_pkg::ST_ADD && (!r_oval || o_out.ready)) begin
            r_oval <= 1'b1;
        end else if (o_out.ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fgal_pkg::ST_ADD && (!r_oval || o_out.ready)) begin
            r_ofound  <= r_found;
            r_oslot   <= r_found & r_slot;
            r_offset  <= r_found ? 24'(r_prod + 29'(w_base)) : 24'd0;
            r_obytes  <= r_found ? r_size[r_slot][7:0] : 8'd0;
            r_owidth  <= r_found ? r_width[r_slot] : 8'd0;
            r_oheight <= r_found ? r_height[r_slot] : 8'd0;
        end
    end

    assign o_out.valid        = r_oval;
    assign o_out.found        = r_ofound;
    assign o_out.font_slot    = r_oslot;
    assign o_out.byte_offset  = r_offset;
    assign o_out.glyph_bytes  = r_obytes;
    assign o_out.glyph_width  = r_owidth;
    assign o_out.glyph_height = r_oheight;
endmodule

FILE: verif/tb_font_glyph_address_lookup.sv
// Testbench: glyph address unit checked against a predictor over configured slots
`timescale 1ns / 100ps

module tb_font_glyph_address_lookup;

    localparam int TABLE_DEPTH = 2 * fgal_pkg::MAX_BLOCKS_DEF;
    localparam int SETTLE      = fgal_pkg::MAX_BLOCKS_DEF + 8;

    typedef struct {
        logic        operation;
        logic        table_slot;
        logic [7:0]  block_index;
        logic [15:0] range_start;
        logic [15:0] range_end;
        logic [15:0] char_code;
    } t_glyph_req;

    typedef struct {
        logic        found;
        logic        font_slot;
        logic [23:0] byte_offset;
        logic [7:0]  glyph_bytes;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
    } t_glyph_res;

    class glyph_offset_predictor;
        logic [1:0]  kind [2];
        logic [7:0]  width [2];
        logic [7:0]  height [2];
        logic [7:0]  blocks [2];
        logic [15:0] first_code [TABLE_DEPTH];
        logic [15:0] last_code [TABLE_DEPTH];
        t_glyph_res  pending_offsets [$];
        int          errors;

        function new();
            kind   = '{2'd0, 2'd0};
            width  = '{8'd8, 8'd16};
            height = '{8'd16, 8'd16};
            blocks = '{8'd0, 8'd0};
            errors = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [7:0] data);
            int s;
            s = idx[2];
            if (idx > fgal_pkg::REG_S1_BLOCKS) return;
            case (idx[1:0])
                2'd0: kind[s] = data[1:0];
                2'd1: width[s] = data;
                2'd2: height[s] = data;
                default: blocks[s] = data;
            endcase
        endfunction

        function t_glyph_res predict(t_glyph_req r);
            t_glyph_res  res;
            int unsigned size, code, e;
            logic [15:0] idx;
            res = '{default: '0};
            if (r.operation == fgal_pkg::OP_LOAD) begin
                e = r.table_slot * fgal_pkg::MAX_BLOCKS_DEF + r.block_index;
                first_code[e] = r.range_start;
                last_code[e]  = r.range_end;
                return res;
            end
            code = r.char_code;
            for (int s = 0; s < 2; s++) begin
                if (kind[s] != fgal_pkg::KIND_SINGLE && kind[s] != fgal_pkg::KIND_DOUBLE) continue;
                size = ((width[s] + 7) / 8) * height[s];
                if (size > fgal_pkg::GLYPH_BUF_BYTES_DEF) continue;
                res.glyph_bytes  = size[7:0];
                res.glyph_width  = width[s];
                res.glyph_height = height[s];
                res.font_slot    = s[0];
                if (code < fgal_pkg::CODE_SB_LIMIT) begin
                    if (kind[s] == fgal_pkg::KIND_SINGLE) begin
                        res.found = 1'b1;
                        res.byte_offset = 24'(fgal_pkg::SB_BASE + code * size);
                        return res;
                    end
                end else if (kind[s] == fgal_pkg::KIND_DOUBLE) begin
                    idx = '0;
                    for (int b = 0; b < blocks[s]; b++) begin
                        e = s * fgal_pkg::MAX_BLOCKS_DEF + b;
                        if (code >= first_code[e] && code <= last_code[e]) begin
                            idx = idx + 16'(code - first_code[e]);
                            res.found = 1'b1;
                            res.byte_offset = 24'(fgal_pkg::DB_BASE + blocks[s] * 4
                                                  + idx * size);
                            return res;
                        end
                        idx = idx + 16'(int'(last_code[e]) - int'(first_code[e]) + 1);
                    end
                end
            end
            return '{default: '0};
        endfunction

        function void note_request(t_glyph_req r);
            pending_offsets.push_back(predict(r));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(t_glyph_res got);
            t_glyph_res w;
            if (pending_offsets.size() == 0) begin
                report("unexpected transaction", got.byte_offset, 0);
                return;
            end
            w = pending_offsets.pop_front();
            if (got.found !== w.found) report("found", got.found, w.found);
            if (got.font_slot !== w.font_slot) report("font_slot", got.font_slot, w.font_slot);
            if (got.byte_offset !== w.byte_offset)
                report("byte_offset", got.byte_offset, w.byte_offset);
            if (got.glyph_bytes !== w.glyph_bytes)
                report("glyph_bytes", got.glyph_bytes, w.glyph_bytes);
            if (got.glyph_width !== w.glyph_width)
                report("glyph_width", got.glyph_width, w.glyph_width);
            if (got.glyph_height !== w.glyph_height)
                report("glyph_height", got.glyph_height, w.glyph_height);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    fgal_in_if  in_ch ();
    fgal_out_if out_ch ();
    fgal_cfg_if cfg_ch ();

    glyph_offset_predictor sb;
    bit quiet;
    bit hold_req;

    font_glyph_address_lookup u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left, hold_left;
        t_glyph_res got;
        stall_left = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.found        = out_ch.found;
                got.font_slot    = out_ch.font_slot;
                got.byte_offset  = out_ch.byte_offset;
                got.glyph_bytes  = out_ch.glyph_bytes;
                got.glyph_width  = out_ch.glyph_width;
                got.glyph_height = out_ch.glyph_height;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 1200;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send(t_glyph_req r);
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= r.operation;
        in_ch.table_slot  <= r.table_slot;
        in_ch.block_index <= r.block_index;
        in_ch.range_start <= r.range_start;
        in_ch.range_end   <= r.range_end;
        in_ch.char_code   <= r.char_code;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic lookup(logic [15:0] code);
        t_glyph_req r;
        r = '{fgal_pkg::OP_LOOKUP, 1'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), code};
        send(r);
    endtask

    task automatic load(logic slot, logic [7:0] b, logic [15:0] first, logic [15:0] last);
        t_glyph_req r;
        r = '{fgal_pkg::OP_LOAD, slot, b, first, last, 16'($urandom)};
        send(r);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_slots(logic [1:0] k0, logic [7:0] w0, logic [7:0] h0, logic [7:0] n0,
                             logic [1:0] k1, logic [7:0] w1, logic [7:0] h1, logic [7:0] n1);
        settle();
        write_reg(fgal_pkg::REG_S0_KIND, {6'd0, k0});
        write_reg(fgal_pkg::REG_S0_WIDTH, w0);
        write_reg(fgal_pkg::REG_S0_HEIGHT, h0);
        write_reg(fgal_pkg::REG_S0_BLOCKS, n0);
        write_reg(fgal_pkg::REG_S1_KIND, {6'd0, k1});
        write_reg(fgal_pkg::REG_S1_WIDTH, w1);
        write_reg(fgal_pkg::REG_S1_HEIGHT, h1);
        write_reg(fgal_pkg::REG_S1_BLOCKS, n1);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] code_in_table();
        int s, b;
        logic [15:0] f, l;
        s = $urandom_range(0, 1);
        if (sb.blocks[s] == 0) s = 1 - s;
        b = sb.blocks[s] == 0 ? $urandom_range(0, 255) : $urandom_range(0, sb.blocks[s] - 1);
        f = sb.first_code[s * fgal_pkg::MAX_BLOCKS_DEF + b];
        l = sb.last_code[s * fgal_pkg::MAX_BLOCKS_DEF + b];
        case ($urandom_range(0, 3))
            0: return f;
            1: return l;
            default: return (l >= f) ? 16'(f + $urandom_range(0, l - f)) : f;
        endcase
    endfunction

    task automatic random_items(int n);
        int sel;
        logic [15:0] f;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                f = 16'($urandom_range(16'h100, 16'hFF00));
                if ($urandom_range(0, 5) == 0)
                    load(1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
                else
                    load(1'($urandom), 8'($urandom), f, 16'(f + $urandom_range(0, 80)));
            end else if (sel < 60) begin
                lookup(code_in_table());
            end else if (sel < 80) begin
                lookup(16'($urandom_range(0, 255)));
            end else begin
                lookup(16'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] cur, len;
        sb = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = fgal_pkg::OP_LOOKUP;
        in_ch.table_slot = 1'b0;
        in_ch.block_index = '0;
        in_ch.range_start = '0;
        in_ch.range_end = '0;
        in_ch.char_code = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no slot present, everything misses
        lookup(16'h0000);
        lookup(16'hFFFF);
        lookup(16'h0100);

        // fill both block tables before any double-byte walk
        for (int s = 0; s < 2; s++) begin
            cur = 16'($urandom_range(16'h100, 16'h8140));
            for (int b = 0; b < fgal_pkg::MAX_BLOCKS_DEF; b++) begin
                len = 16'($urandom_range(0, 63));
                if ($urandom_range(0, 15) == 0)
                    load(s[0], b[7:0], 16'($urandom), 16'($urandom));
                else
                    load(s[0], b[7:0], cur, 16'(cur + len));
                cur = 16'(cur + len + 1 + $urandom_range(0, 3));
            end
        end
        load(1'b1, 8'd255, 16'hFFFF, 16'hFFFF);

        // out-of-range register index is ignored
        settle();
        write_reg(8'hFF, 8'h55);
        cfg_ch.valid <= 1'b0;

        set_slots(fgal_pkg::KIND_SINGLE, 8'd8, 8'd16, 8'd0,
                  fgal_pkg::KIND_DOUBLE, 8'd16, 8'd16, 8'd255);
        lookup(16'h0000);
        lookup(16'h00FF);
        lookup(16'h0100);
        lookup(16'hFFFF);
        lookup(sb.first_code[fgal_pkg::MAX_BLOCKS_DEF]);
        lookup(sb.last_code[fgal_pkg::MAX_BLOCKS_DEF + 254]);
        random_items(110);

        set_slots(fgal_pkg::KIND_DOUBLE, 8'd255, 8'd0, 8'd0,
                  fgal_pkg::KIND_SINGLE, 8'd0, 8'd255, 8'd255);
        lookup(16'h00A5);
        lookup(16'h5A5A);
        random_items(100);

        set_slots(2'd3, 8'd8, 8'd8, 8'd255, fgal_pkg::KIND_DOUBLE, 8'd24, 8'd42, 8'd17);
        random_items(100);

        set_slots(fgal_pkg::KIND_DOUBLE, 8'd16, 8'd16, 8'd40,
                  fgal_pkg::KIND_DOUBLE, 8'd8, 8'd16, 8'd255);
        hold_req = 1'b1;
        random_items(120);

        set_slots(fgal_pkg::KIND_SINGLE, 8'd9, 8'd64, 8'd3,
                  fgal_pkg::KIND_SINGLE, 8'd255, 8'd255, 8'd0);
        lookup(16'h00FF);
        random_items(100);

        set_slots(fgal_pkg::KIND_SINGLE, 8'd17, 8'd43, 8'd1,
                  fgal_pkg::KIND_DOUBLE, 8'd16, 8'd8, 8'd200);
        random_items(110);

        set_slots(fgal_pkg::KIND_SINGLE, 8'd8, 8'd16, 8'd128,
                  fgal_pkg::KIND_DOUBLE, 8'd16, 8'd16, 8'd128);
        quiet = 1'b1;
        random_items(140);

        in_ch.valid <= 1'b0;
        while (sb.pending_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
